// ===== rtl/yuyvtpg_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV test pattern generator package
// Shared widths, register codes, colour constants and structs.
// ----------------------------------------------------------------------------
package yuyvtpg_pkg;

  // Raster coordinate width and side of the moving square.
  localparam int COORD_BITS  = 12;
  localparam int SQUARE_SIDE = 100;
  localparam int SQUARE_STEP = 10;

  // Fixed register widths.
  localparam int GRAY_BITS = 8;
  localparam int MODE_BITS = 2;
  localparam int DIM_BITS  = 12;
  localparam int CFG_BITS  = 12;
  localparam int IDX_BITS  = 2;
  localparam int PIX_BITS  = 8;
  localparam int FRAME_BITS = 32;

  // Width for coordinate versus frame size compares, with room for
  // a sum of a coordinate and a small step or a tripled coordinate.
  localparam int CMP_W = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 2;

  // Width for the square's right and bottom bounds.
  localparam int SIDE_BITS = $clog2(SQUARE_SIDE + 1);
  localparam int SQ_W = ((COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS) + 1;

  // Configuration register indexes.
  typedef enum logic [IDX_BITS-1:0] {
    REG_GRAY   = 2'd0,
    REG_MODE   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  // Pattern mode codes; any other code draws gray.
  localparam logic [MODE_BITS-1:0] MODE_SQUARE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BARS   = 2'd2;

  // Reset values of the registers.
  localparam logic [GRAY_BITS-1:0] GRAY_RESET   = 8'd128;
  localparam logic [MODE_BITS-1:0] MODE_RESET   = 2'd0;
  localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 12'd480;

  // Colours.
  localparam logic [PIX_BITS-1:0] CHROMA_NEUTRAL = 8'd128;
  localparam logic [PIX_BITS-1:0] Y_WHITE  = 8'd255;
  localparam logic [PIX_BITS-1:0] BAR0_Y = 8'd76;
  localparam logic [PIX_BITS-1:0] BAR0_U = 8'd84;
  localparam logic [PIX_BITS-1:0] BAR0_V = 8'd255;
  localparam logic [PIX_BITS-1:0] BAR1_Y = 8'd149;
  localparam logic [PIX_BITS-1:0] BAR1_U = 8'd43;
  localparam logic [PIX_BITS-1:0] BAR1_V = 8'd21;
  localparam logic [PIX_BITS-1:0] BAR2_Y = 8'd76;
  localparam logic [PIX_BITS-1:0] BAR2_U = 8'd255;
  localparam logic [PIX_BITS-1:0] BAR2_V = 8'd104;

  typedef struct packed {
    logic [GRAY_BITS-1:0] gray;
    logic [MODE_BITS-1:0] mode;
    logic [DIM_BITS-1:0]  width;
    logic [DIM_BITS-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [FRAME_BITS-1:0] frame_count;
    logic [COORD_BITS-1:0] sq_left;
    logic [COORD_BITS-1:0] sq_top;
  } pos_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] y;
    logic [PIX_BITS-1:0] u;
    logic [PIX_BITS-1:0] v;
  } color_t;

endpackage

// ===== rtl/yuyvtpg_if.sv =====
// ----------------------------------------------------------------------------
// YUYV test pattern generator channels
// Valid/ready channels for the tick input and the pixel pair output.
// ----------------------------------------------------------------------------
interface yuyvtpg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface yuyvtpg_out_if;
  logic                               valid;
  logic                               ready;
  logic [yuyvtpg_pkg::PIX_BITS-1:0]   luma;
  logic [yuyvtpg_pkg::PIX_BITS-1:0]   chroma_u;
  logic [yuyvtpg_pkg::PIX_BITS-1:0]   chroma_v;
  logic                               line_end;
  logic                               frame_end;
  logic [yuyvtpg_pkg::FRAME_BITS-1:0] frame_number;

  modport source (output valid, output luma, output chroma_u, output chroma_v,
                  output line_end, output frame_end, output frame_number,
                  input ready);
  modport sink   (input valid, input luma, input chroma_u, input chroma_v,
                  input line_end, input frame_end, input frame_number,
                  output ready);
endinterface

// ===== rtl/yuyvtpg_raster.sv =====
// ----------------------------------------------------------------------------
// YUYV test pattern generator raster counter
// Column, row, frame count and square origin, advanced once per transfer.
// ----------------------------------------------------------------------------
module yuyvtpg_raster (
  input  logic                 clk,
  input  logic                 rst_n,
  input  yuyvtpg_pkg::cfg_t    cfg,
  input  logic                 step,
  input  logic                 restart,
  output yuyvtpg_pkg::pos_t    cur,
  output logic                 line_end,
  output logic                 frame_end
);
  import yuyvtpg_pkg::*;

  pos_t pos_r, pos_nxt;

  // Move an origin by one step and fold it back into the frame.
  function automatic logic [COORD_BITS-1:0] advance(input logic [COORD_BITS-1:0] p,
                                                   input logic [DIM_BITS-1:0] size);
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] sz;
    sz = CMP_W'(size);
    s  = CMP_W'(p) + CMP_W'(SQUARE_STEP);
    if (s >= sz) begin
      s = s - sz;
      if (s >= sz) begin
        s = '0;
      end
    end
    return s[COORD_BITS-1:0];
  endfunction

  // A restart clears the position before this pair is drawn.
  always_comb begin
    cur = restart ? '0 : pos_r;
  end

  assign line_end  = (CMP_W'(cur.column) + CMP_W'(2)) >= CMP_W'(cfg.width);
  assign frame_end = line_end && ((CMP_W'(cur.row) + CMP_W'(1)) >= CMP_W'(cfg.height));

  always_comb begin
    pos_nxt = cur;
    if (frame_end) begin
      pos_nxt.column      = '0;
      pos_nxt.row         = '0;
      pos_nxt.frame_count = cur.frame_count + FRAME_BITS'(1);
      pos_nxt.sq_left     = advance(cur.sq_left, cfg.width);
      pos_nxt.sq_top      = advance(cur.sq_top, cfg.height);
    end else if (line_end) begin
      pos_nxt.column = '0;
      pos_nxt.row    = cur.row + COORD_BITS'(1);
    end else begin
      pos_nxt.column = cur.column + COORD_BITS'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== rtl/yuyvtpg_color.sv =====
// ----------------------------------------------------------------------------
// YUYV test pattern generator colour select
// Picks the Y/U/V value of a pixel pair from its position and the mode.
// ----------------------------------------------------------------------------
module yuyvtpg_color (
  input  yuyvtpg_pkg::cfg_t    cfg,
  input  yuyvtpg_pkg::pos_t    cur,
  output yuyvtpg_pkg::color_t  color
);
  import yuyvtpg_pkg::*;

  logic [CMP_W-1:0] col3p3;
  logic [CMP_W-1:0] w1;
  logic [CMP_W-1:0] w2;
  logic [SQ_W-1:0]  col_s;
  logic [SQ_W-1:0]  row_s;
  logic [SQ_W-1:0]  left_s;
  logic [SQ_W-1:0]  top_s;
  logic             in_square;

  // column < floor(w/3) holds exactly when 3*column + 3 <= w, so the bar
  // edges need no divider.
  assign col3p3 = (CMP_W'(cur.column) << 1) + CMP_W'(cur.column) + CMP_W'(3);
  assign w1     = CMP_W'(cfg.width);
  assign w2     = w1 << 1;

  assign col_s  = SQ_W'(cur.column);
  assign row_s  = SQ_W'(cur.row);
  assign left_s = SQ_W'(cur.sq_left);
  assign top_s  = SQ_W'(cur.sq_top);

  assign in_square = (col_s >= left_s) && (col_s < left_s + SQ_W'(SQUARE_SIDE)) &&
                     (row_s >= top_s) && (row_s < top_s + SQ_W'(SQUARE_SIDE));

  always_comb begin
    color.y = cfg.gray;
    color.u = CHROMA_NEUTRAL;
    color.v = CHROMA_NEUTRAL;
    case (cfg.mode)
      MODE_SQUARE: begin
        if (in_square) begin
          color.y = Y_WHITE;
        end
      end
      MODE_BARS: begin
        if (col3p3 <= w1) begin
          color.y = BAR0_Y;
          color.u = BAR0_U;
          color.v = BAR0_V;
        end else if (col3p3 <= w2) begin
          color.y = BAR1_Y;
          color.u = BAR1_U;
          color.v = BAR1_V;
        end else begin
          color.y = BAR2_Y;
          color.u = BAR2_U;
          color.v = BAR2_V;
        end
      end
      default: begin
        color.y = cfg.gray;
      end
    endcase
  end

endmodule

// ===== rtl/yuyv_test_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// YUYV test pattern generator core
// Produces one YUYV pixel pair in raster order for every input transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on in_ch is a tick that asks for the next pixel pair. Its
// restart bit, when set, returns the raster to the top-left corner, clears
// the frame number and puts the moving square back at the origin before
// that pair is drawn. Each tick gives exactly one transfer on out_ch with
// luma, chroma_u, chroma_v, the line_end and frame_end flags and the number
// of the frame the pair belongs to.
// A tick accepted at a clock edge is shown on out_ch right after it.
// Throughput is one pair per clock while the receiver takes pairs; this is
// set by the single output register, which reloads in the cycle it is emptied.
// When the receiver stalls, the held pair stays on out_ch and in_ch.ready
// drops until the pair is taken, so no tick is lost.
// The cfg port writes gray_level, pattern_mode, frame_width and
// frame_height by index; writes take effect at once and are meant for idle
// periods. Reset (rst_n low at a clock edge) restores the register
// defaults of gray 128, mode 0 and 640x480, clears the raster and empties
// the output register.
// ----------------------------------------------------------------------------
module yuyv_test_pattern_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [yuyvtpg_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [yuyvtpg_pkg::CFG_BITS-1:0] cfg_wdata,
  yuyvtpg_in_if.sink                    in_ch,
  yuyvtpg_out_if.source                 out_ch
);
  import yuyvtpg_pkg::*;

  cfg_t   cfg_r;
  pos_t   cur;
  color_t color;
  logic   line_end;
  logic   frame_end;
  logic   in_take;

  logic                  out_valid_r;
  color_t                out_color_r;
  logic                  out_line_end_r;
  logic                  out_frame_end_r;
  logic [FRAME_BITS-1:0] out_frame_r;

  // Configuration registers. An index is decoded against the register codes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gray   <= GRAY_RESET;
      cfg_r.mode   <= MODE_RESET;
      cfg_r.width  <= WIDTH_RESET;
      cfg_r.height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRAY:   cfg_r.gray   <= cfg_wdata[GRAY_BITS-1:0];
        REG_MODE:   cfg_r.mode   <= cfg_wdata[MODE_BITS-1:0];
        REG_WIDTH:  cfg_r.width  <= cfg_wdata[DIM_BITS-1:0];
        REG_HEIGHT: cfg_r.height <= cfg_wdata[DIM_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // A tick is taken whenever the output register is empty or is being
  // emptied in this same cycle, so pairs stream at one per clock.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  yuyvtpg_raster u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (in_take),
    .restart   (in_ch.restart),
    .cur       (cur),
    .line_end  (line_end),
    .frame_end (frame_end)
  );

  yuyvtpg_color u_color (
    .cfg   (cfg_r),
    .cur   (cur),
    .color (color)
  );

  // Output register: only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_color_r     <= color;
      out_line_end_r  <= line_end;
      out_frame_end_r <= frame_end;
      out_frame_r     <= cur.frame_count;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.luma         = out_color_r.y;
  assign out_ch.chroma_u     = out_color_r.u;
  assign out_ch.chroma_v     = out_color_r.v;
  assign out_ch.line_end     = out_line_end_r;
  assign out_ch.frame_end    = out_frame_end_r;
  assign out_ch.frame_number = out_frame_r;

endmodule
